// ----- src/wsc_pkg.sv -----
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants of the waypoint steering command block
// Field widths, action codes, register indexes and pipeline dimensions.
// ----------------------------------------------------------------------------
package wsc_pkg;

   localparam int POS_W     = 20;
   localparam int HEAD_W    = 15;
   localparam int TURN_W    = 16;
   localparam int SPEED_W   = 14;
   localparam int TRIG_W    = 15;
   localparam int DIFF_W    = 21;
   localparam int RX_W      = 23;
   localparam int NUM_W     = 48;
   localparam int DEN_W     = 44;
   localparam int DIV_BITS  = 25;
   localparam int SC_LAT    = 12;
   localparam int ANGLE_W   = 12;

   localparam logic [HEAD_W-1:0] HALF_TURN    = 15'd11520;
   localparam logic [HEAD_W-1:0] FULL_TURN    = 15'd23040;
   localparam logic [HEAD_W-1:0] QUARTER_TURN = 15'd5760;
   localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 15'd17280;
   localparam logic [HEAD_W-1:0] EIGHTH_TURN  = 15'd2880;

   localparam logic [1:0] ACT_FORWARD   = 2'd0;
   localparam logic [1:0] ACT_PIVOT_NEG = 2'd1;
   localparam logic [1:0] ACT_PIVOT_POS = 2'd2;

   localparam logic [2:0] REG_HALF_WHEEL = 3'd0;
   localparam logic [2:0] REG_OFFSET     = 3'd1;
   localparam logic [2:0] REG_FWD_SPEED  = 3'd2;
   localparam logic [2:0] REG_PIV_SPEED  = 3'd3;
   localparam logic [2:0] REG_PIV_THRESH = 3'd4;
   localparam logic [2:0] REG_MIN_FWD    = 3'd5;

   typedef struct packed {
      logic signed [POS_W-1:0]  cur_x;
      logic signed [POS_W-1:0]  cur_y;
      logic        [HEAD_W-1:0] cur_heading;
      logic signed [POS_W-1:0]  goal_x;
      logic signed [POS_W-1:0]  goal_y;
      logic        [HEAD_W-1:0] goal_heading;
   } req_item_type;

endpackage

// ----- src/wsc_req_if.sv -----
// ----------------------------------------------------------------------------
// wsc_req_if: pose request channel
// Valid/ready channel carrying the current and the target pose.
// ----------------------------------------------------------------------------
interface wsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] cur_x;
   logic signed [19:0] cur_y;
   logic        [14:0] cur_heading;
   logic signed [19:0] goal_x;
   logic signed [19:0] goal_y;
   logic        [14:0] goal_heading;

   modport source (output valid, cur_x, cur_y, cur_heading, goal_x, goal_y, goal_heading,
                   input ready);
   modport sink   (input valid, cur_x, cur_y, cur_heading, goal_x, goal_y, goal_heading,
                   output ready);
endinterface

// ----- src/wsc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wsc_rsp_if: steering command channel
// Valid/ready channel carrying one steering command.
// ----------------------------------------------------------------------------
interface wsc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic signed [15:0] turn_command;
   logic signed [13:0] speed_command;

   modport source (output valid, action, turn_command, speed_command, input ready);
   modport sink   (input valid, action, turn_command, speed_command, output ready);
endinterface

// ----- src/wsc_sincos.sv -----
// ----------------------------------------------------------------------------
// wsc_sincos: pipelined octant sine and cosine
// Taylor series in Q.30 (sine to x^7, cosine to x^8), results in Q.14.
// ----------------------------------------------------------------------------
module wsc_sincos (
   input  logic                          clock,
   input  logic                          en,
   input  logic [wsc_pkg::ANGLE_W-1:0]   angle,
   output logic [wsc_pkg::TRIG_W-1:0]    sin_oct,
   output logic [wsc_pkg::TRIG_W-1:0]    cos_oct
);
   import wsc_pkg::*;

   localparam logic [18:0] RAD_Q30 = 19'd292818;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [31:0] M42 = 32'((64'd1 << 32) / 42);
   localparam logic [31:0] M56 = 32'((64'd1 << 32) / 56);
   localparam logic [31:0] M20 = 32'((64'd1 << 32) / 20);
   localparam logic [31:0] M30 = 32'((64'd1 << 32) / 30);
   localparam logic [31:0] M6  = 32'((64'd1 << 32) / 6);
   localparam logic [31:0] M12 = 32'((64'd1 << 32) / 12);

   // quotient estimate, low by at most one
   function automatic logic [29:0] quot_est(input logic [29:0] v, input logic [31:0] m);
      logic [61:0] p;
      p = v * m;
      return p[61:32];
   endfunction

   function automatic logic [30:0] one_minus(input logic [29:0] v, input logic [29:0] q,
                                             input logic [5:0] d);
      logic [35:0] qd;
      logic [29:0] r;
      logic [29:0] qq;
      qd = q * d;
      r  = v - qd[29:0];
      qq = (r >= {24'd0, d}) ? q + 30'd1 : q;
      return ONE_Q30 - {1'b0, qq};
   endfunction

   function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
      logic [60:0] p;
      p = a * b;
      return p[59:30];
   endfunction

   logic [30:0] x1_in;
   logic [29:0] x1_ff;
   logic [29:0] xs_ff [2:10];
   logic [29:0] x2_ff [2:10];
   logic [29:0] qs3_ff, qc3_ff, qs6_ff, qc6_ff, qs9_ff, qc9_ff;
   logic [30:0] ts4_ff, tc4_ff, ts7_ff, tc7_ff, ts10_ff, tc10_ff;
   logic [29:0] ps5_ff, pc5_ff, ps6_ff, pc6_ff, ps8_ff, pc8_ff, ps9_ff, pc9_ff;
   logic [29:0] ps11_ff, pc11_ff;
   logic [30:0] cfin_in;
   logic [30:0] sr_in, cr_in;
   logic [TRIG_W-1:0] sin_ff, cos_ff;

   assign x1_in   = angle * RAD_Q30;
   assign cfin_in = ONE_Q30 - {2'b0, pc11_ff[29:1]};
   assign sr_in   = {1'b0, ps11_ff} + 31'h8000;
   assign cr_in   = cfin_in + 31'h8000;

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x1_in[29:0];
         xs_ff[2] <= x1_ff;
         x2_ff[2] <= mul_q30(x1_ff, {1'b0, x1_ff});
         for (int i = 3; i <= 10; i++) begin
            xs_ff[i] <= xs_ff[i-1];
            x2_ff[i] <= x2_ff[i-1];
         end
         qs3_ff  <= quot_est(x2_ff[2], M42);
         qc3_ff  <= quot_est(x2_ff[2], M56);
         ts4_ff  <= one_minus(x2_ff[3], qs3_ff, 6'd42);
         tc4_ff  <= one_minus(x2_ff[3], qc3_ff, 6'd56);
         ps5_ff  <= mul_q30(x2_ff[4], ts4_ff);
         pc5_ff  <= mul_q30(x2_ff[4], tc4_ff);
         qs6_ff  <= quot_est(ps5_ff, M20);
         qc6_ff  <= quot_est(pc5_ff, M30);
         ps6_ff  <= ps5_ff;
         pc6_ff  <= pc5_ff;
         ts7_ff  <= one_minus(ps6_ff, qs6_ff, 6'd20);
         tc7_ff  <= one_minus(pc6_ff, qc6_ff, 6'd30);
         ps8_ff  <= mul_q30(x2_ff[7], ts7_ff);
         pc8_ff  <= mul_q30(x2_ff[7], tc7_ff);
         qs9_ff  <= quot_est(ps8_ff, M6);
         qc9_ff  <= quot_est(pc8_ff, M12);
         ps9_ff  <= ps8_ff;
         pc9_ff  <= pc8_ff;
         ts10_ff <= one_minus(ps9_ff, qs9_ff, 6'd6);
         tc10_ff <= one_minus(pc9_ff, qc9_ff, 6'd12);
         ps11_ff <= mul_q30(xs_ff[10], ts10_ff);
         pc11_ff <= mul_q30(x2_ff[10], tc10_ff);
         // round to Q.14
         sin_ff  <= sr_in[30:16];
         cos_ff  <= cr_in[30:16];
      end
   end

   assign sin_oct = sin_ff;
   assign cos_oct = cos_ff;

endmodule

// ----- src/wsc_divider.sv -----
// ----------------------------------------------------------------------------
// wsc_divider: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in DIV_BITS bits.
// ----------------------------------------------------------------------------
module wsc_divider (
   input  logic                          clock,
   input  logic                          en,
   input  logic [wsc_pkg::NUM_W-1:0]     num,
   input  logic [wsc_pkg::DEN_W-1:0]     den,
   output logic [wsc_pkg::DIV_BITS-1:0]  quo
);
   import wsc_pkg::*;

   localparam int HI_W = NUM_W - DIV_BITS;

   logic [DEN_W-1:0]    rem_ff [DIV_BITS];
   logic [DIV_BITS-1:0] nlo_ff [DIV_BITS];
   logic [DIV_BITS-1:0] q_ff   [DIV_BITS];
   logic [DEN_W-1:0]    den_ff [DIV_BITS];

   logic [DEN_W-1:0]    rem_src [DIV_BITS];
   logic [DIV_BITS-1:0] nlo_src [DIV_BITS];
   logic [DIV_BITS-1:0] q_src   [DIV_BITS];
   logic [DEN_W-1:0]    den_src [DIV_BITS];

   for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
      logic [DEN_W:0] trial;
      if (g == 0) begin : g_first
         assign rem_src[g] = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:DIV_BITS]};
         assign nlo_src[g] = num[DIV_BITS-1:0];
         assign q_src[g]   = '0;
         assign den_src[g] = den;
      end else begin : g_next
         assign rem_src[g] = rem_ff[g-1];
         assign nlo_src[g] = nlo_ff[g-1];
         assign q_src[g]   = q_ff[g-1];
         assign den_src[g] = den_ff[g-1];
      end
      assign trial = {rem_src[g], nlo_src[g][DIV_BITS-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, den_src[g]}) begin
               rem_ff[g] <= DEN_W'(trial - {1'b0, den_src[g]});
               q_ff[g]   <= {q_src[g][DIV_BITS-2:0], 1'b1};
            end else begin
               rem_ff[g] <= trial[DEN_W-1:0];
               q_ff[g]   <= {q_src[g][DIV_BITS-2:0], 1'b0};
            end
            nlo_ff[g] <= {nlo_src[g][DIV_BITS-2:0], 1'b0};
            den_ff[g] <= den_src[g];
         end
      end
   end

   assign quo = q_ff[DIV_BITS-1];

endmodule

// ----- src/waypoint_steering_command.sv -----
// ----------------------------------------------------------------------------
// waypoint_steering_command: steering command from current and waypoint pose
// Pivot or arc-following command per pose sample, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: send one pose sample (current and target pose) per transfer on
// req_chan; one command comes back on rsp_chan for each, in order.
// The path from request transfer to response valid: input
// register, heading and offset stage, 12 sine/cosine stages, frame
// rotation in three stages, arc terms in two stages, a 25-stage
// restoring divider (one quotient bit per stage) and the output register.
// One command and one new request per cycle while rsp_chan does not stall.
// Configuration goes through the APB-style csr_ port, registers at 4*i, and
// is meant to be written only while no request is in flight.
// Reset clears all valid bits and loads the register defaults; there is
// no clearing pass.
// When rsp_chan stalls the whole pipeline holds; the input register still
// takes one request if it is empty, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module waypoint_steering_command (
   input  logic        clock,
   input  logic        reset,
   wsc_req_if.sink     req_chan,
   wsc_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wsc_pkg::*;

   // ---------------- configuration registers ----------------
   logic [11:0]        hw_ff;
   logic signed [12:0] offset_ff;
   logic [12:0]        fwd_ff;
   logic [12:0]        pivot_ff;
   logic [13:0]        thresh_ff;
   logic [11:0]        minfwd_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff     <= 12'd410;
         offset_ff <= 13'sd287;
         fwd_ff    <= 13'd819;
         pivot_ff  <= 13'd1229;
         thresh_ff <= 14'd5120;
         minfwd_ff <= 12'd205;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_HALF_WHEEL: hw_ff     <= csr_pwdata[11:0];
            REG_OFFSET:     offset_ff <= csr_pwdata[12:0];
            REG_FWD_SPEED:  fwd_ff    <= csr_pwdata[12:0];
            REG_PIV_SPEED:  pivot_ff  <= csr_pwdata[12:0];
            REG_PIV_THRESH: thresh_ff <= csr_pwdata[13:0];
            REG_MIN_FWD:    minfwd_ff <= csr_pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HALF_WHEEL: csr_prdata = {20'd0, hw_ff};
         REG_OFFSET:     csr_prdata = {{19{offset_ff[12]}}, offset_ff};
         REG_FWD_SPEED:  csr_prdata = {19'd0, fwd_ff};
         REG_PIV_SPEED:  csr_prdata = {19'd0, pivot_ff};
         REG_PIV_THRESH: csr_prdata = {18'd0, thresh_ff};
         REG_MIN_FWD:    csr_prdata = {20'd0, minfwd_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic req_xfer;
   logic out_v_ff;
   logic in_v_ff;

   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en || !in_v_ff;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // ---------------- input register ----------------
   req_item_type in_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff.cur_x        <= req_chan.cur_x;
         in_ff.cur_y        <= req_chan.cur_y;
         in_ff.cur_heading  <= req_chan.cur_heading;
         in_ff.goal_x       <= req_chan.goal_x;
         in_ff.goal_y       <= req_chan.goal_y;
         in_ff.goal_heading <= req_chan.goal_heading;
      end
   end

   // ---------------- stage A: heading error, octant, offsets ----------------
   typedef struct packed {
      logic [1:0]               action;
      logic [1:0]               quad;
      logic                     swap;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } side_a_type;

   logic signed [16:0] err_raw, err_in, thr_s;
   logic [HEAD_W-1:0]  head_in, rem_in;
   logic [1:0]         quad_in;
   logic [ANGLE_W-1:0] angle_in, angle_ff;
   side_a_type         a_in, a_ff;
   logic               a_v_ff;

   always_comb begin
      err_raw = $signed({2'b0, in_ff.goal_heading}) - $signed({2'b0, in_ff.cur_heading});
      // wrap once into half turns
      if (err_raw > $signed({2'b0, HALF_TURN}))
         err_in = err_raw - $signed({2'b0, FULL_TURN});
      else if (err_raw < -$signed({2'b0, HALF_TURN}))
         err_in = err_raw + $signed({2'b0, FULL_TURN});
      else
         err_in = err_raw;
      thr_s = $signed({3'b0, thresh_ff});
      if (err_in > thr_s)
         a_in.action = ACT_PIVOT_NEG;
      else if (err_in < -thr_s)
         a_in.action = ACT_PIVOT_POS;
      else
         a_in.action = ACT_FORWARD;

      head_in = (in_ff.cur_heading >= FULL_TURN) ? in_ff.cur_heading - FULL_TURN
                                                 : in_ff.cur_heading;
      if (head_in >= THREE_QUARTER_TURN) begin
         quad_in = 2'd3;
         rem_in  = head_in - THREE_QUARTER_TURN;
      end else if (head_in >= HALF_TURN) begin
         quad_in = 2'd2;
         rem_in  = head_in - HALF_TURN;
      end else if (head_in >= QUARTER_TURN) begin
         quad_in = 2'd1;
         rem_in  = head_in - QUARTER_TURN;
      end else begin
         quad_in = 2'd0;
         rem_in  = head_in;
      end
      a_in.quad = quad_in;
      a_in.swap = rem_in > EIGHTH_TURN;
      angle_in  = a_in.swap ? ANGLE_W'(QUARTER_TURN - rem_in) : rem_in[ANGLE_W-1:0];
      a_in.dx   = DIFF_W'(in_ff.goal_x) - DIFF_W'(in_ff.cur_x);
      a_in.dy   = DIFF_W'(in_ff.goal_y) - DIFF_W'(in_ff.cur_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         angle_ff <= angle_in;
      end
   end

   // ---------------- sine / cosine ----------------
   logic [TRIG_W-1:0] sin_oct, cos_oct;
   side_a_type        sbl_ff [SC_LAT];
   logic              sbl_v_ff [SC_LAT];

   wsc_sincos u_sincos (
      .clock   (clock),
      .en      (en),
      .angle   (angle_ff),
      .sin_oct (sin_oct),
      .cos_oct (cos_oct)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sbl_ff[0] <= a_ff;
         for (int i = 1; i < SC_LAT; i++)
            sbl_ff[i] <= sbl_ff[i-1];
      end
   end

   // ---------------- stage M: quadrant mapping ----------------
   logic signed [15:0] bs, bc, s_in, c_in, m_s_ff, m_c_ff;
   logic signed [DIFF_W-1:0] m_dx_ff, m_dy_ff;
   logic [1:0]  m_act_ff;
   logic        m_v_ff;
   side_a_type  sb_last;

   assign sb_last = sbl_ff[SC_LAT-1];

   always_comb begin
      bs = sb_last.swap ? $signed({1'b0, cos_oct}) : $signed({1'b0, sin_oct});
      bc = sb_last.swap ? $signed({1'b0, sin_oct}) : $signed({1'b0, cos_oct});
      case (sb_last.quad)
         2'd0: begin
            s_in = bs;
            c_in = bc;
         end
         2'd1: begin
            s_in = bc;
            c_in = -bs;
         end
         2'd2: begin
            s_in = -bs;
            c_in = -bc;
         end
         default: begin
            s_in = -bc;
            c_in = bs;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_s_ff   <= s_in;
         m_c_ff   <= c_in;
         m_dx_ff  <= sb_last.dx;
         m_dy_ff  <= sb_last.dy;
         m_act_ff <= sb_last.action;
      end
   end

   // ---------------- stage N: rotation products ----------------
   logic signed [36:0] dxc_in, dys_in, dyc_in, dxs_in;
   logic signed [36:0] dxc_ff, dys_ff, dyc_ff, dxs_ff;
   logic [1:0] n_act_ff;
   logic       n_v_ff;

   assign dxc_in = m_dx_ff * m_c_ff;
   assign dys_in = m_dy_ff * m_s_ff;
   assign dyc_in = m_dy_ff * m_c_ff;
   assign dxs_in = m_dx_ff * m_s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dxc_ff   <= dxc_in;
         dys_ff   <= dys_in;
         dyc_ff   <= dyc_in;
         dxs_ff   <= dxs_in;
         n_act_ff <= m_act_ff;
      end
   end

   // ---------------- stage O: robot frame offsets ----------------
   logic signed [37:0] rxs_in, rys_in;
   logic signed [RX_W-1:0] rx_ff, ry_ff;
   logic [1:0] o_act_ff;
   logic       o_v_ff;

   assign rxs_in = 38'(dxc_ff) + 38'(dys_ff);
   assign rys_in = 38'(dyc_ff) - 38'(dxs_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         // floor shift by 14
         rx_ff    <= rxs_in[RX_W+13:14];
         ry_ff    <= rys_in[RX_W+13:14];
         o_act_ff <= n_act_ff;
      end
   end

   // ---------------- stage P: arc terms ----------------
   logic signed [2*RX_W-1:0] rx2_in, ry2_in;
   logic [33:0]      hwrx_in, hwrx_ff;
   logic [DEN_W-1:0] rx2_ff, ry2_ff;
   logic             gate_in, p_gate_ff;
   logic [1:0]       p_act_ff;
   logic             p_v_ff;

   assign rx2_in  = rx_ff * rx_ff;
   assign ry2_in  = ry_ff * ry_ff;
   assign hwrx_in = hw_ff * rx_ff[RX_W-2:0];
   assign gate_in = rx_ff > $signed({{(RX_W-12){1'b0}}, minfwd_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         rx2_ff    <= rx2_in[DEN_W-1:0];
         ry2_ff    <= ry2_in[DEN_W-1:0];
         hwrx_ff   <= hwrx_in;
         p_gate_ff <= gate_in;
         p_act_ff  <= o_act_ff;
      end
   end

   // ---------------- stage Q: divider operands ----------------
   typedef struct packed {
      logic [1:0] action;
      logic       gate;
   } side_d_type;

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   side_d_type       q_sb_ff;
   logic             q_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         // feed a harmless division when no arc is fitted
         num_ff         <= p_gate_ff ? {1'b0, hwrx_ff, 13'd0} : '0;
         den_ff         <= p_gate_ff ? DEN_W'(rx2_ff + ry2_ff) : DEN_W'(1);
         q_sb_ff.action <= p_act_ff;
         q_sb_ff.gate   <= p_gate_ff;
      end
   end

   // ---------------- divider ----------------
   logic [DIV_BITS-1:0] quo;
   side_d_type          dl_ff   [DIV_BITS];
   logic                dl_v_ff [DIV_BITS];

   wsc_divider u_divider (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff[0] <= q_sb_ff;
         for (int i = 1; i < DIV_BITS; i++)
            dl_ff[i] <= dl_ff[i-1];
      end
   end

   // ---------------- output stage ----------------
   side_d_type                dl_last;
   logic signed [DIV_BITS+1:0] turn_sum;
   logic signed [TURN_W-1:0]   turn_in, turn_ff;
   logic signed [SPEED_W-1:0]  speed_in, speed_ff;
   logic [1:0]                 act_ff;

   assign dl_last = dl_ff[DIV_BITS-1];

   always_comb begin
      turn_sum = $signed({2'b0, (dl_last.gate ? quo : {DIV_BITS{1'b0}})})
               + (DIV_BITS+2)'(offset_ff);
      if (turn_sum > (DIV_BITS+2)'(32767))
         turn_in = 16'sh7FFF;
      else if (turn_sum < -(DIV_BITS+2)'(32768))
         turn_in = -16'sh8000;
      else
         turn_in = turn_sum[TURN_W-1:0];
      case (dl_last.action)
         ACT_PIVOT_NEG: begin
            turn_in  = '0;
            speed_in = -$signed({1'b0, pivot_ff});
         end
         ACT_PIVOT_POS: begin
            turn_in  = '0;
            speed_in = $signed({1'b0, pivot_ff});
         end
         default: speed_in = $signed({1'b0, fwd_ff});
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         turn_ff  <= turn_in;
         speed_ff <= speed_in;
         act_ff   <= dl_last.action;
      end
   end

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.action        = act_ff;
   assign rsp_chan.turn_command  = turn_ff;
   assign rsp_chan.speed_command = speed_ff;

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         a_v_ff   <= 1'b0;
         m_v_ff   <= 1'b0;
         n_v_ff   <= 1'b0;
         o_v_ff   <= 1'b0;
         p_v_ff   <= 1'b0;
         q_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < SC_LAT; i++)
            sbl_v_ff[i] <= 1'b0;
         for (int i = 0; i < DIV_BITS; i++)
            dl_v_ff[i] <= 1'b0;
      end else begin
         if (en) begin
            in_v_ff     <= req_xfer;
            a_v_ff      <= in_v_ff;
            sbl_v_ff[0] <= a_v_ff;
            for (int i = 1; i < SC_LAT; i++)
               sbl_v_ff[i] <= sbl_v_ff[i-1];
            m_v_ff     <= sbl_v_ff[SC_LAT-1];
            n_v_ff     <= m_v_ff;
            o_v_ff     <= n_v_ff;
            p_v_ff     <= o_v_ff;
            q_v_ff     <= p_v_ff;
            dl_v_ff[0] <= q_v_ff;
            for (int i = 1; i < DIV_BITS; i++)
               dl_v_ff[i] <= dl_v_ff[i-1];
            out_v_ff <= dl_v_ff[DIV_BITS-1];
         end else if (req_xfer) begin
            // hold the pipeline, take one request into the empty input register
            in_v_ff <= 1'b1;
         end
      end
   end

   // ---------------- assertions ----------------
   a_ready_low_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (out_v_ff && !rsp_chan.ready && in_v_ff))
      else $error("request side stalled without a held response");

   a_pivot_zero_turn: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && act_ff != ACT_FORWARD) |-> (turn_ff == 16'sd0))
      else $error("pivot command with nonzero turn");

   a_forward_speed: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && act_ff == ACT_FORWARD) |-> (speed_ff == $signed({1'b0, fwd_ff})))
      else $error("forward command with wrong speed");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(q_v_ff) && $stable(num_ff) && $stable(den_ff)))
      else $error("divider operands moved during a stall");

endmodule
